// ===== hdl/edpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpc_pkg
// Shared types, request codes and channel range table for the encoder
// detent parameter controller.
// ----------------------------------------------------------------------------
package edpc_pkg;

    localparam int CH_MAX            = 8;
    localparam int NUM_CHANNELS_DEF  = 8;
    localparam int STEP_INTERVAL_DEF = 60;
    localparam int SPIKE_LIMIT_DEF   = 40;

    localparam logic [2:0] REQ_ROTATE    = 3'd0;
    localparam logic [2:0] REQ_BUTTON    = 3'd1;
    localparam logic [2:0] REQ_SET       = 3'd2;
    localparam logic [2:0] REQ_RESET_ALL = 3'd3;
    localparam logic [2:0] REQ_READ      = 3'd4;

    localparam logic [1:0] KIND_CHANGE = 2'd0;
    localparam logic [1:0] KIND_RESET  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] REG_NOTIFY_EN  = 2'd0;
    localparam logic [1:0] REG_THROTTLE   = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE   = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  channel;
        logic signed [7:0] enc_delta;
        logic        pressed;
        logic [15:0] set_val;
        logic        notify;
        logic [31:0] now_ms;
    } edpc_in_t;

    typedef struct packed {
        logic [2:0] out_channel;
        logic [7:0] out_value;
        logic [1:0] kind;
        logic       last;
    } edpc_out_t;

    // classified command passed from front to back
    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  channel;
        logic        dir_up;
        logic        is_pair_cand;
        logic        pressed;
        logic [15:0] set_val;
        logic        notify;
        logic [31:0] now_ms;
    } edpc_cmd_t;

    function automatic logic [7:0] ch_lo(input logic [2:0] ch);
        case (ch)
            3'd3:    ch_lo = 8'd1;
            default: ch_lo = 8'd0;
        endcase
    endfunction

    function automatic logic [7:0] ch_hi(input logic [2:0] ch);
        case (ch)
            3'd0:    ch_hi = 8'd95;
            3'd2:    ch_hi = 8'd63;
            3'd3:    ch_hi = 8'd100;
            default: ch_hi = 8'd255;
        endcase
    endfunction

    function automatic logic [7:0] ch_dflt(input logic [2:0] ch);
        case (ch)
            3'd1, 3'd4, 3'd6: ch_dflt = 8'd128;
            3'd3:             ch_dflt = 8'd25;
            3'd5:             ch_dflt = 8'd255;
            default:          ch_dflt = 8'd0;
        endcase
    endfunction

endpackage

// ===== hdl/edpc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpc_front
// Accepts requests, drops spikes, zero moves, unknown types and bad channels
// (not for read/reset-all), and queues classified commands for the back end.
// ----------------------------------------------------------------------------
module edpc_front
    import edpc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SPIKE_LIMIT  = SPIKE_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  edpc_in_t   in_data,
    output logic       cmd_valid,
    input  logic       cmd_take,
    output edpc_cmd_t  cmd
);

    localparam int ACTIVE = (NUM_CHANNELS < CH_MAX) ? NUM_CHANNELS : CH_MAX;

    edpc_cmd_t  q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep, acc;
    logic       ch_ok;
    logic signed [8:0] d9;
    edpc_cmd_t  c;

    assign in_stall = (cnt_reg == 2'd2);
    assign acc      = in_valid && !in_stall;
    assign d9       = 9'(in_data.enc_delta);
    assign ch_ok    = 32'(in_data.channel) < ACTIVE;

    always_comb
    begin
        c.req_type     = in_data.req_type;
        c.channel      = in_data.channel;
        c.dir_up       = !in_data.enc_delta[7];
        c.is_pair_cand = (d9 == 9'sd1) || (d9 == -9'sd1);
        c.pressed      = in_data.pressed;
        c.set_val      = in_data.set_val;
        c.notify       = in_data.notify;
        c.now_ms       = in_data.now_ms;
        case (in_data.req_type)
            REQ_RESET_ALL, REQ_READ: keep = 1'b1;
            REQ_BUTTON, REQ_SET:     keep = ch_ok;
            REQ_ROTATE:              keep = ch_ok && (d9 != 9'sd0)
                                         && (d9 <= 9'(SPIKE_LIMIT))
                                         && (d9 >= -9'(SPIKE_LIMIT));
            default:                 keep = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (acc && keep)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (acc && keep)
        begin
            wp_next = !wp_reg;
        end
        if (cmd_take)
        begin
            rp_next = !rp_reg;
        end
        cnt_next = cnt_reg + 2'(acc && keep) - 2'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

endmodule

// ===== hdl/edpc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpc_back
// Executes queued commands against per-channel state and emits results
// through an output register.
// ----------------------------------------------------------------------------
module edpc_back
    import edpc_pkg::*;
#(
    parameter int NUM_CHANNELS     = NUM_CHANNELS_DEF,
    parameter int STEP_INTERVAL_MS = STEP_INTERVAL_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_take,
    input  edpc_cmd_t  cmd,
    input  logic       notify_en,
    input  logic [15:0] throttle_ms,
    input  logic [15:0] debounce_ms,
    output logic       out_valid,
    input  logic       out_stall,
    output edpc_out_t  out_data
);

    localparam int ACTIVE = (NUM_CHANNELS < CH_MAX) ? NUM_CHANNELS : CH_MAX;
    localparam logic [2:0] LAST_CH = 3'(ACTIVE - 1);

    typedef enum logic [1:0] {
        ST_EXEC  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t      st_reg, st_next;
    logic [2:0]  sw_reg, sw_next;
    logic [7:0]  val_reg  [CH_MAX];
    logic [1:0]  pend_reg [CH_MAX];
    logic [CH_MAX-1:0] await_reg, bst_reg, bprev_reg;
    logic [31:0] step_t_reg [CH_MAX];
    logic [31:0] note_t_reg [CH_MAX];
    logic [31:0] btn_t_reg  [CH_MAX];
    logic        ov_reg;
    edpc_out_t   od_reg;

    logic        out_free;
    logic [2:0]  ch;
    logic [7:0]  cur, lo, hi, nw, setv;
    logic [8:0]  up, dn;
    logic [1:0]  sgn;
    logic        pair_ok, step_ok, thr_ok, deb_ok;
    logic        emit;
    edpc_out_t   res;

    assign out_free  = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign ch        = cmd.channel;
    assign cur       = val_reg[ch];
    assign lo        = ch_lo(ch);
    assign hi        = ch_hi(ch);
    assign sgn       = cmd.dir_up ? 2'd1 : 2'd3;
    assign pair_ok   = await_reg[ch] && (pend_reg[ch] == sgn);
    assign step_ok   = (cmd.now_ms - step_t_reg[ch]) >= 32'(STEP_INTERVAL_MS);
    assign thr_ok    = (cmd.now_ms - note_t_reg[ch]) >= {16'd0, throttle_ms};
    assign deb_ok    = (cmd.now_ms - btn_t_reg[ch]) >= {16'd0, debounce_ms};
    assign up        = {1'b0, cur} + 9'd1;
    assign dn        = {1'b0, cur} - 9'd1;

    always_comb
    begin
        if (cmd.dir_up)
        begin
            if (up > {1'b0, hi})
                nw = (ch == 3'd0 || ch == 3'd2) ? lo : hi;
            else
                nw = up[7:0];
        end
        else
        begin
            if (cur == 8'd0 || dn < {1'b0, lo})
                nw = (ch == 3'd0 || ch == 3'd2) ? hi : lo;
            else
                nw = dn[7:0];
        end
        if (cmd.set_val < {8'd0, lo})
            setv = lo;
        else if (cmd.set_val > {8'd0, hi})
            setv = hi;
        else
            setv = cmd.set_val[7:0];
    end

    always_comb
    begin
        st_next  = st_reg;
        sw_next  = sw_reg;
        cmd_take = 1'b0;
        emit     = 1'b0;
        res      = '{out_channel: ch, out_value: cur, kind: KIND_CHANGE, last: 1'b1};
        case (st_reg)
            ST_EXEC:
            begin
                if (cmd_valid && out_free)
                begin
                    case (cmd.req_type)
                        REQ_RESET_ALL:
                        begin
                            st_next = ST_SWEEP;
                            sw_next = 3'd0;
                        end
                        REQ_READ:
                        begin
                            cmd_take = 1'b1;
                            emit     = 1'b1;
                            res.kind = KIND_READ;
                            res.out_value = (32'(ch) < ACTIVE) ? cur : 8'd0;
                        end
                        REQ_ROTATE:
                        begin
                            cmd_take = 1'b1;
                            res.out_value = nw;
                            emit = (!cmd.is_pair_cand || pair_ok) && step_ok
                                && (nw != cur) && notify_en && thr_ok;
                        end
                        REQ_BUTTON:
                        begin
                            cmd_take = 1'b1;
                            res.kind = KIND_RESET;
                            res.out_value = ch_dflt(ch);
                            emit = (cmd.pressed != bst_reg[ch]) && (btn_t_reg[ch] != 32'd0)
                                && deb_ok && cmd.pressed && !bprev_reg[ch] && notify_en;
                        end
                        REQ_SET:
                        begin
                            cmd_take = 1'b1;
                            res.out_value = setv;
                            emit = (setv != cur) && cmd.notify && notify_en;
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (out_free)
                begin
                    res.out_channel = sw_reg;
                    res.out_value   = ch_dflt(sw_reg);
                    res.kind        = KIND_RESET;
                    res.last        = (sw_reg == LAST_CH);
                    emit            = notify_en;
                    sw_next         = sw_reg + 3'd1;
                    if (sw_reg == LAST_CH)
                    begin
                        st_next  = ST_EXEC;
                        cmd_take = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_EXEC;
            sw_reg    <= 3'd0;
            ov_reg    <= 1'b0;
            await_reg <= '0;
            bst_reg   <= '0;
            bprev_reg <= '0;
            for (int i = 0; i < CH_MAX; i++)
            begin
                val_reg[i]    <= ch_dflt(3'(i));
                pend_reg[i]   <= 2'd0;
                step_t_reg[i] <= 32'd0;
                note_t_reg[i] <= 32'd0;
                btn_t_reg[i]  <= 32'd0;
            end
        end
        else
        begin
            st_reg <= st_next;
            sw_reg <= sw_next;
            if (out_free)
            begin
                ov_reg <= emit;
            end
            if (st_reg == ST_SWEEP && out_free)
            begin
                val_reg[sw_reg] <= ch_dflt(sw_reg);
            end
            if (st_reg == ST_EXEC && cmd_take)
            begin
                case (cmd.req_type)
                    REQ_ROTATE:
                    begin
                        if (cmd.is_pair_cand && !pair_ok)
                        begin
                            pend_reg[ch]  <= sgn;
                            await_reg[ch] <= 1'b1;
                        end
                        else
                        begin
                            pend_reg[ch]  <= 2'd0;
                            await_reg[ch] <= 1'b0;
                            if (step_ok)
                            begin
                                step_t_reg[ch] <= cmd.now_ms;
                                val_reg[ch]    <= nw;
                                if (nw != cur && notify_en && thr_ok)
                                    note_t_reg[ch] <= cmd.now_ms;
                            end
                        end
                    end
                    REQ_BUTTON:
                    begin
                        if (cmd.pressed != bst_reg[ch])
                        begin
                            if (btn_t_reg[ch] == 32'd0)
                                btn_t_reg[ch] <= cmd.now_ms;
                            else if (deb_ok)
                            begin
                                bst_reg[ch]   <= cmd.pressed;
                                btn_t_reg[ch] <= 32'd0;
                                bprev_reg[ch] <= cmd.pressed;
                                if (cmd.pressed && !bprev_reg[ch])
                                    val_reg[ch] <= ch_dflt(ch);
                            end
                        end
                        else
                        begin
                            btn_t_reg[ch] <= 32'd0;
                            bprev_reg[ch] <= cmd.pressed;
                        end
                    end
                    REQ_SET:
                    begin
                        val_reg[ch] <= setv;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && emit)
        begin
            od_reg <= res;
        end
    end

endmodule

// ===== hdl/encoder_detent_parameter_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_detent_parameter_controller
// Eight-channel encoder parameter controller with detent debounce, button
// reset, set, read and reset-all requests.
// ----------------------------------------------------------------------------
// A request transaction is taken into a two-entry command queue while it is
// not full; the back end executes one command per cycle unless the output is
// stalled, so rotation, button, set and read requests sustain one transaction
// per cycle, each result passing through the command queue and the output
// register. A reset-all request holds the back end while it sweeps each active
// channel in turn, emitting one result per channel when notices are enabled.
// Results wait in an output register while stalled.
module encoder_detent_parameter_controller
    import edpc_pkg::*;
#(
    parameter int NUM_CHANNELS     = NUM_CHANNELS_DEF,
    parameter int STEP_INTERVAL_MS = STEP_INTERVAL_DEF,
    parameter int SPIKE_LIMIT      = SPIKE_LIMIT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  edpc_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output edpc_out_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        nen_reg;
    logic [15:0] thr_reg, deb_reg;
    logic        cmd_valid, cmd_take;
    edpc_cmd_t   cmd;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nen_reg <= 1'b0;
            thr_reg <= 16'd50;
            deb_reg <= 16'd50;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_NOTIFY_EN: nen_reg <= pwdata[0];
                REG_THROTTLE:  thr_reg <= pwdata[15:0];
                REG_DEBOUNCE:  deb_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_NOTIFY_EN: prdata = {31'd0, nen_reg};
            REG_THROTTLE:  prdata = {16'd0, thr_reg};
            REG_DEBOUNCE:  prdata = {16'd0, deb_reg};
            default:       prdata = 32'd0;
        endcase
    end

    edpc_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SPIKE_LIMIT  (SPIKE_LIMIT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    edpc_back #(
        .NUM_CHANNELS     (NUM_CHANNELS),
        .STEP_INTERVAL_MS (STEP_INTERVAL_MS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd         (cmd),
        .notify_en   (nen_reg),
        .throttle_ms (thr_reg),
        .debounce_ms (deb_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// ===== hdl/edpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edpc_checker
// Port-level checks for the encoder detent parameter controller.
// ----------------------------------------------------------------------------
module edpc_checker
    import edpc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input edpc_out_t out_data,
    input logic      pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.kind != 2'd3)
        else $error("undefined result kind");

    a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind != KIND_RESET |-> out_data.last)
        else $error("single result without last");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind encoder_detent_parameter_controller edpc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .pready    (pready)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the encoder detent parameter controller. Requests
// are driven with random idle gaps and output stalls; a predictor of the
// channel state works out the expected results, and a scoreboard checks each
// result transaction in order. Several register settings are exercised.
// ----------------------------------------------------------------------------
module tb_top;
    import edpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    class result_board;
        edpc_out_t pending[$];
        int        errors;

        function void note(edpc_out_t r);
            pending.push_back(r);
        endfunction

        function void check(edpc_out_t r);
            edpc_out_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result ch=%0d val=%0d kind=%0d", r.out_channel,
                    r.out_value, r.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.out_channel !== r.out_channel)
            begin
                $error("out_channel exp %0d got %0d", e.out_channel, r.out_channel);
                errors++;
            end
            if (e.out_value !== r.out_value)
            begin
                $error("out_value exp %0d got %0d", e.out_value, r.out_value);
                errors++;
            end
            if (e.kind !== r.kind)
            begin
                $error("kind exp %0d got %0d", e.kind, r.kind);
                errors++;
            end
            if (e.last !== r.last)
            begin
                $error("last exp %0d got %0d", e.last, r.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    edpc_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    edpc_out_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    encoder_detent_parameter_controller dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    result_board board;

    logic        m_notify_en;
    logic [15:0] m_throttle;
    logic [15:0] m_debounce;
    logic [7:0]  m_value [8];
    logic [1:0]  m_sign [8];
    logic        m_await [8];
    logic [31:0] m_step_t [8];
    logic [31:0] m_notice_t [8];
    logic        m_btn_stable [8];
    logic        m_btn_prev [8];
    logic [31:0] m_btn_t [8];

    logic [31:0] clock_ms;
    int          idle_pct_in;
    int          idle_pct_out;
    bit          hold_req;
    bit          hold_out;
    int          quiet_cycles;
    bit          timed_out;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] step_channel(int ch, logic [7:0] v, bit up);
        int n;
        n = up ? int'(v) + 1 : int'(v) - 1;
        if (ch == 0 || ch == 2)
        begin
            if (n > int'(ch_hi(3'(ch)))) n = int'(ch_lo(3'(ch)));
            if (n < int'(ch_lo(3'(ch)))) n = int'(ch_hi(3'(ch)));
        end
        else
        begin
            if (n > int'(ch_hi(3'(ch)))) n = int'(ch_hi(3'(ch)));
            if (n < int'(ch_lo(3'(ch)))) n = int'(ch_lo(3'(ch)));
        end
        return n[7:0];
    endfunction

    function automatic edpc_out_t mk(logic [2:0] ch, logic [7:0] v, logic [1:0] k,
        logic l);
        edpc_out_t r;
        r.out_channel = ch;
        r.out_value   = v;
        r.kind        = k;
        r.last        = l;
        return r;
    endfunction

    task automatic predict_request(edpc_in_t q);
        int          ch;
        int          d;
        logic [1:0]  sg;
        bit          release_step;
        logic [7:0]  nw;
        logic [15:0] c;
        ch = int'(q.channel);
        d  = int'(q.enc_delta);
        case (q.req_type)
            REQ_RESET_ALL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    m_value[i] = ch_dflt(3'(i));
                    if (m_notify_en)
                        board.note(mk(3'(i), m_value[i], KIND_RESET, i == 7));
                end
            end
            REQ_READ: board.note(mk(q.channel, m_value[ch], KIND_READ, 1'b1));
            REQ_ROTATE:
            begin
                if (d != 0 && d <= 40 && d >= -40)
                begin
                    sg = d > 0 ? 2'd1 : 2'd3;
                    release_step = 1'b1;
                    if ((d == 1 || d == -1) && (!m_await[ch] || m_sign[ch] != sg))
                    begin
                        m_sign[ch]  = sg;
                        m_await[ch] = 1'b1;
                        release_step = 1'b0;
                    end
                    if (release_step)
                    begin
                        m_sign[ch]  = 2'd0;
                        m_await[ch] = 1'b0;
                        if (q.now_ms - m_step_t[ch] >= 32'd60)
                        begin
                            m_step_t[ch] = q.now_ms;
                            nw = step_channel(ch, m_value[ch], d > 0);
                            if (nw != m_value[ch] && m_notify_en &&
                                q.now_ms - m_notice_t[ch] >= {16'd0, m_throttle})
                            begin
                                m_notice_t[ch] = q.now_ms;
                                board.note(mk(q.channel, nw, KIND_CHANGE, 1'b1));
                            end
                            m_value[ch] = nw;
                        end
                    end
                end
            end
            REQ_BUTTON:
            begin
                if (q.pressed != m_btn_stable[ch])
                begin
                    if (m_btn_t[ch] == 0)
                        m_btn_t[ch] = q.now_ms;
                    else if (q.now_ms - m_btn_t[ch] >= {16'd0, m_debounce})
                    begin
                        m_btn_stable[ch] = q.pressed;
                        m_btn_t[ch] = 0;
                        if (q.pressed && !m_btn_prev[ch])
                        begin
                            m_value[ch] = ch_dflt(q.channel);
                            if (m_notify_en)
                                board.note(mk(q.channel, m_value[ch], KIND_RESET, 1'b1));
                        end
                        m_btn_prev[ch] = q.pressed;
                    end
                end
                else
                begin
                    m_btn_t[ch] = 0;
                    m_btn_prev[ch] = q.pressed;
                end
            end
            REQ_SET:
            begin
                c = q.set_val;
                if (c < {8'd0, ch_lo(q.channel)}) c = {8'd0, ch_lo(q.channel)};
                if (c > {8'd0, ch_hi(q.channel)}) c = {8'd0, ch_hi(q.channel)};
                if (c[7:0] != m_value[ch])
                begin
                    m_value[ch] = c[7:0];
                    if (q.notify && m_notify_en)
                        board.note(mk(q.channel, c[7:0], KIND_CHANGE, 1'b1));
                end
            end
            default: ;
        endcase
    endtask

    task automatic send(edpc_in_t q);
        while (idle_pct_in > 0 && $urandom_range(99) < idle_pct_in)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_request(q);
    endtask

    task automatic req(logic [2:0] t, logic [2:0] ch, logic [7:0] d, logic p,
        logic [15:0] nv, logic n, logic [31:0] now);
        edpc_in_t q;
        q.req_type  = t;
        q.channel   = ch;
        q.enc_delta = d;
        q.pressed   = p;
        q.set_val   = nv;
        q.notify    = n;
        q.now_ms    = now;
        send(q);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0 && !timed_out) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NOTIFY_EN: m_notify_en = v[0];
            REG_THROTTLE:  m_throttle  = v[15:0];
            REG_DEBOUNCE:  m_debounce  = v[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic random_request();
        edpc_in_t q;
        int       r;
        r = int'($urandom_range(99));
        clock_ms = clock_ms + $urandom_range(80);
        q.channel   = 3'($urandom_range(7));
        q.enc_delta = 8'($urandom);
        q.pressed   = 1'($urandom);
        q.set_val   = 16'($urandom);
        q.notify    = 1'($urandom);
        q.now_ms    = clock_ms;
        if (r < 35)
        begin
            q.req_type = REQ_ROTATE;
            if ($urandom_range(3) != 0) q.enc_delta = $urandom_range(1) ? 8'd1 : 8'hff;
            else if ($urandom_range(1)) q.enc_delta = $urandom_range(1) ? 8'd2 : 8'hfe;
        end
        else if (r < 60)
            q.req_type = REQ_BUTTON;
        else if (r < 75)
        begin
            q.req_type = REQ_SET;
            if ($urandom_range(1)) q.set_val = 16'($urandom_range(300));
        end
        else if (r < 90)
            q.req_type = REQ_READ;
        else if (r < 95)
            q.req_type = REQ_RESET_ALL;
        else
        begin
            q.req_type = 3'($urandom_range(7, 5));
            q.now_ms   = $urandom;
        end
        send(q);
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall) board.check(out_data);
        if (hold_out || (idle_pct_out > 0 && $urandom_range(99) < idle_pct_out))
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        board = new();
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        quiet_cycles = 0; timed_out = 1'b0; hold_req = 1'b0;
        idle_pct_in = 25; idle_pct_out = 25; clock_ms = 32'd100;
        m_notify_en = 1'b0; m_throttle = 16'd50; m_debounce = 16'd50;
        for (int i = 0; i < 8; i++)
        begin
            m_value[i] = ch_dflt(3'(i)); m_sign[i] = 0; m_await[i] = 0;
            m_step_t[i] = 0; m_notice_t[i] = 0; m_btn_stable[i] = 0;
            m_btn_prev[i] = 0; m_btn_t[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        req(REQ_READ, 3'd7, 8'd0, 1'b0, 16'd0, 1'b0, 32'd0);
        req(REQ_ROTATE, 3'd0, 8'd2, 1'b0, 16'd0, 1'b0, 32'd100);
        write_reg(REG_NOTIFY_EN, 32'd1);
        write_reg(REG_THROTTLE, 32'd0);
        write_reg(REG_DEBOUNCE, 32'd0);
        req(REQ_ROTATE, 3'd0, 8'hfe, 1'b0, 16'd0, 1'b0, 32'd200);
        req(REQ_ROTATE, 3'd2, 8'd1, 1'b0, 16'd0, 1'b0, 32'd300);
        req(REQ_ROTATE, 3'd2, 8'd1, 1'b0, 16'd0, 1'b0, 32'd301);
        req(REQ_ROTATE, 3'd1, 8'd40, 1'b0, 16'd0, 1'b0, 32'd400);
        req(REQ_ROTATE, 3'd1, 8'hd8, 1'b0, 16'd0, 1'b0, 32'd410);
        req(REQ_ROTATE, 3'd1, 8'd41, 1'b0, 16'd0, 1'b0, 32'd500);
        req(REQ_ROTATE, 3'd1, 8'h80, 1'b0, 16'd0, 1'b0, 32'd600);
        req(REQ_ROTATE, 3'd1, 8'd0, 1'b0, 16'd0, 1'b0, 32'd700);
        req(REQ_ROTATE, 3'd5, 8'h7f, 1'b0, 16'd0, 1'b0, 32'd800);
        req(REQ_ROTATE, 3'd3, 8'hf0, 1'b0, 16'd0, 1'b0, 32'd900);
        req(REQ_SET, 3'd3, 8'd0, 1'b0, 16'hffff, 1'b1, 32'hffffffff);
        req(REQ_SET, 3'd3, 8'd0, 1'b0, 16'd100, 1'b1, 32'd0);
        req(REQ_SET, 3'd3, 8'd0, 1'b0, 16'd0, 1'b0, 32'd0);
        req(REQ_BUTTON, 3'd4, 8'd0, 1'b1, 16'd0, 1'b0, 32'd0);
        req(REQ_BUTTON, 3'd4, 8'd0, 1'b1, 16'd0, 1'b0, 32'd5);
        req(REQ_BUTTON, 3'd4, 8'd0, 1'b1, 16'd0, 1'b0, 32'd6);
        req(REQ_BUTTON, 3'd4, 8'd0, 1'b0, 16'd0, 1'b0, 32'd7);
        req(REQ_RESET_ALL, 3'd6, 8'd0, 1'b0, 16'd0, 1'b0, 32'd8);
        req(3'd7, 3'd1, 8'd0, 1'b0, 16'd0, 1'b0, 32'd9);
        req(3'd5, 3'd1, 8'd0, 1'b0, 16'd0, 1'b0, 32'd9);
        req(REQ_READ, 3'd3, 8'd0, 1'b0, 16'd0, 1'b0, 32'd10);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_THROTTLE, 32'd50); write_reg(REG_DEBOUNCE, 32'd50); end
                1: begin write_reg(REG_THROTTLE, 32'hffff); write_reg(REG_DEBOUNCE, 32'hffff);
                   end
                2: begin write_reg(REG_NOTIFY_EN, 32'd0); write_reg(REG_DEBOUNCE, 32'd20); end
                default: begin write_reg(REG_NOTIFY_EN, 32'd1);
                   write_reg(REG_THROTTLE, 32'd30); write_reg(REG_DEBOUNCE, 32'd10); end
            endcase
            for (int n = 0; n < 80; n++)
            begin
                if (phase == 1 && n == 0) idle_pct_in = 0;
                if (phase == 1 && n == 10) hold_req = 1'b1;
                if (phase == 1 && n == 40) idle_pct_in = 25;
                if (phase == 3 && n == 0) begin idle_pct_in = 0; idle_pct_out = 0; end
                if (phase == 3 && n == 40) begin idle_pct_in = 25; idle_pct_out = 25; end
                random_request();
                if (phase == 0 && n == 40) drain();
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : hold_window
        hold_out = 1'b0;
        wait (hold_req);
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
    end
endmodule

// ===== sim.f =====
hdl/edpc_pkg.sv
hdl/edpc_front.sv
hdl/edpc_back.sv
hdl/encoder_detent_parameter_controller.sv
hdl/edpc_checker.sv
tb/tb_top.sv
